>>> hw/rtl/rgbi420_pkg.sv
package rgbi420_pkg;

   localparam int FRAME_WIDTH_BITS  = 13;
   localparam int FRAME_HEIGHT_BITS = 13;
   localparam int BPP_BITS          = 3;
   localparam int CSR_DATA_BITS     = 13;

   localparam int COMPONENT_BITS  = 8;
   localparam int LUMA_ADDR_BITS  = 24;
   localparam int CHROMA_POS_BITS = 22;
   localparam int CHROMA_ADDR_BITS = 25;
   localparam int SRC_ADDR_BITS   = 26;
   localparam int SRC_INDEX_BITS  = 24;

   localparam int LUMA_SUM_BITS   = 16;
   localparam int CHROMA_SUM_BITS = 17;

   localparam int Y_R_WEIGHT  = 66;
   localparam int Y_G_WEIGHT  = 129;
   localparam int Y_B_WEIGHT  = 25;
   localparam int CB_R_WEIGHT = 38;
   localparam int CB_G_WEIGHT = 74;
   localparam int CB_B_WEIGHT = 112;
   localparam int CR_R_WEIGHT = 112;
   localparam int CR_G_WEIGHT = 94;
   localparam int CR_B_WEIGHT = 18;
   localparam int LUMA_OFFSET   = 16;
   localparam int CHROMA_OFFSET = 128;
   localparam int CHROMA_BIAS   = 32768;
   localparam int WEIGHT_SHIFT  = 8;

   localparam logic [FRAME_WIDTH_BITS-1:0]  FRAME_WIDTH_RESET  = 13'd2;
   localparam logic [FRAME_HEIGHT_BITS-1:0] FRAME_HEIGHT_RESET = 13'd1;
   localparam logic [BPP_BITS-1:0]          BPP_RESET          = 3'd4;

   typedef enum logic [1:0] {
      CSR_FRAME_WIDTH,
      CSR_FRAME_HEIGHT,
      CSR_FLIP_VERTICAL,
      CSR_BYTES_PER_PIXEL
   } csr_index_type;

   typedef struct packed {
      logic [COMPONENT_BITS-1:0] red;
      logic [COMPONENT_BITS-1:0] green;
      logic [COMPONENT_BITS-1:0] blue;
   } req_payload_type;

   typedef struct packed {
      logic [COMPONENT_BITS-1:0]   luma;
      logic [LUMA_ADDR_BITS-1:0]   luma_address;
      logic                        chroma_valid;
      logic [COMPONENT_BITS-1:0]   blue_diff;
      logic [COMPONENT_BITS-1:0]   red_diff;
      logic [CHROMA_ADDR_BITS-1:0] cb_address;
      logic [CHROMA_ADDR_BITS-1:0] cr_address;
      logic [SRC_ADDR_BITS-1:0]    source_address;
      logic                        last_of_frame;
   } rsp_payload_type;

endpackage

>>> hw/rtl/rgb_to_i420_converter.sv
// Channel | Dir | Handshake             | Beat
// req     | in  | req_valid/req_stall   | one RGB pixel, raster order
// rsp     | out | rsp_valid/rsp_stall   | Y, optional Cb/Cr, plane and source offsets
// csr     | in  | csr_write             | register index and data, no read-back
//
// One pixel per clock unless rsp_stall holds; a beat is registered in both stages.
// Stage one walks the frame counters, stage two does the weight sums and the
// offset products. Frame size products are registered from the config port.
// Synchronous active-high reset clears counters and valids, sets config defaults.
// rsp_stall holds both stages; req_stall rises only when both stages are full.
module rgb_to_i420_converter #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  rgbi420_pkg::req_payload_type            req_data,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output rgbi420_pkg::rsp_payload_type            rsp_data,
   input  logic                                    csr_write,
   input  rgbi420_pkg::csr_index_type              csr_index,
   input  logic [rgbi420_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import rgbi420_pkg::*;

   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HH = $clog2(MAX_HEIGHT + 1);
   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int RH = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int PLANE_BITS = WW + HH;
   localparam int SUM_BITS = (PLANE_BITS + 2 > CHROMA_ADDR_BITS) ?
                             PLANE_BITS + 2 : CHROMA_ADDR_BITS;
   localparam int SRC_PROD_BITS = SRC_INDEX_BITS + BPP_BITS;
   localparam int W_CAP_I = MAX_WIDTH - (MAX_WIDTH % 2);
   localparam logic [FRAME_WIDTH_BITS:0]  W_CAP = W_CAP_I[FRAME_WIDTH_BITS:0];
   localparam logic [FRAME_HEIGHT_BITS:0] H_CAP = MAX_HEIGHT[FRAME_HEIGHT_BITS:0];

   function automatic logic [WW-1:0] clamp_width(input logic [FRAME_WIDTH_BITS-1:0] raw);
      logic [FRAME_WIDTH_BITS:0] w;
      w = {1'b0, raw[FRAME_WIDTH_BITS-1:1], 1'b0};
      if (w < (FRAME_WIDTH_BITS+1)'(2)) w = (FRAME_WIDTH_BITS+1)'(2);
      if (w > W_CAP) w = W_CAP;
      return WW'(w);
   endfunction

   function automatic logic [HH-1:0] clamp_height(input logic [FRAME_HEIGHT_BITS-1:0] raw);
      logic [FRAME_HEIGHT_BITS:0] h;
      h = {1'b0, raw};
      if (h == '0) h = (FRAME_HEIGHT_BITS+1)'(1);
      if (h > H_CAP) h = H_CAP;
      return HH'(h);
   endfunction

   // configuration
   logic [FRAME_WIDTH_BITS-1:0]  frame_width_ff, frame_width_in;
   logic [FRAME_HEIGHT_BITS-1:0] frame_height_ff, frame_height_in;
   logic                         flip_ff, flip_in;
   logic [BPP_BITS-1:0]          bpp_ff, bpp_in;
   logic [PLANE_BITS-1:0]        plane_ff, plane_in;
   logic [SRC_INDEX_BITS-1:0]    last_row_start_ff, last_row_start_in;
   logic [WW-1:0]                width_next;
   logic [HH-1:0]                height_next;
   logic [PLANE_BITS-1:0]        last_row_prod;

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      flip_in         = flip_ff;
      bpp_in          = bpp_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_FRAME_WIDTH: begin
               frame_width_in = csr_wdata[FRAME_WIDTH_BITS-1:0];
            end
            CSR_FRAME_HEIGHT: begin
               frame_height_in = csr_wdata[FRAME_HEIGHT_BITS-1:0];
            end
            CSR_FLIP_VERTICAL: begin
               flip_in = csr_wdata[0];
            end
            CSR_BYTES_PER_PIXEL: begin
               bpp_in = csr_wdata[BPP_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
      width_next        = clamp_width(frame_width_in);
      height_next       = clamp_height(frame_height_in);
      plane_in          = PLANE_BITS'(width_next) * PLANE_BITS'(height_next);
      last_row_prod     = PLANE_BITS'(width_next) * PLANE_BITS'(height_next - HH'(1));
      last_row_start_in = SRC_INDEX_BITS'(last_row_prod);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff    <= FRAME_WIDTH_RESET;
         frame_height_ff   <= FRAME_HEIGHT_RESET;
         flip_ff           <= 1'b0;
         bpp_ff            <= BPP_RESET;
         plane_ff          <= PLANE_BITS'(2);
         last_row_start_ff <= '0;
      end else begin
         frame_width_ff    <= frame_width_in;
         frame_height_ff   <= frame_height_in;
         flip_ff           <= flip_in;
         bpp_ff            <= bpp_in;
         plane_ff          <= plane_in;
         last_row_start_ff <= last_row_start_in;
      end
   end

   // handshake
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_ready, s1_ready, req_accept;

   assign out_ready  = !rsp_valid_ff || !rsp_stall;
   assign s1_ready   = !s1_valid_ff || out_ready;
   assign req_accept = req_valid && s1_ready;
   assign req_stall  = !s1_ready;

   // frame walk at accept
   logic [CW-1:0]              column_ff, column_in, column_cur;
   logic [RH-1:0]              row_ff, row_in, row_cur;
   logic [LUMA_ADDR_BITS-1:0]  luma_pos_ff, luma_pos_in, luma_pos_cur;
   logic [CHROMA_POS_BITS-1:0] chroma_pos_ff, chroma_pos_in, chroma_pos_cur;
   logic [SRC_INDEX_BITS-1:0]  src_row_ff, src_row_in, src_row_cur;
   logic [WW-1:0]              width_cur;
   logic [HH-1:0]              height_cur;
   logic                       restart, chroma_cur, row_end, frame_end;

   always_comb begin
      width_cur  = clamp_width(frame_width_ff);
      height_cur = clamp_height(frame_height_ff);
      restart    = (WW'(column_ff) >= width_cur) || (HH'(row_ff) >= height_cur);

      column_cur     = restart ? '0 : column_ff;
      row_cur        = restart ? '0 : row_ff;
      luma_pos_cur   = restart ? '0 : luma_pos_ff;
      chroma_pos_cur = restart ? '0 : chroma_pos_ff;
      src_row_cur    = restart ? '0 : src_row_ff;
      if (column_cur == '0 && row_cur == '0) begin
         src_row_cur = flip_ff ? last_row_start_ff : '0;
      end

      chroma_cur = !row_cur[0] && !column_cur[0];
      row_end    = WW'(column_cur) == width_cur - WW'(1);
      frame_end  = row_end && (HH'(row_cur) == height_cur - HH'(1));

      column_in     = column_cur + CW'(1);
      row_in        = row_cur;
      luma_pos_in   = luma_pos_cur + LUMA_ADDR_BITS'(1);
      chroma_pos_in = chroma_pos_cur + CHROMA_POS_BITS'(chroma_cur);
      src_row_in    = src_row_cur;
      if (row_end) begin
         column_in  = '0;
         row_in     = row_cur + RH'(1);
         src_row_in = flip_ff ? src_row_cur - SRC_INDEX_BITS'(width_cur)
                              : src_row_cur + SRC_INDEX_BITS'(width_cur);
      end
      if (frame_end) begin
         column_in     = '0;
         row_in        = '0;
         luma_pos_in   = '0;
         chroma_pos_in = '0;
         src_row_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff     <= '0;
         row_ff        <= '0;
         luma_pos_ff   <= '0;
         chroma_pos_ff <= '0;
         src_row_ff    <= '0;
      end else if (req_accept) begin
         column_ff     <= column_in;
         row_ff        <= row_in;
         luma_pos_ff   <= luma_pos_in;
         chroma_pos_ff <= chroma_pos_in;
         src_row_ff    <= src_row_in;
      end
   end

   // stage one register
   req_payload_type            s1_pixel_ff;
   logic                       s1_chroma_ff;
   logic                       s1_last_ff;
   logic [SRC_INDEX_BITS-1:0]  s1_src_index_ff;
   logic [LUMA_ADDR_BITS-1:0]  s1_luma_pos_ff;
   logic [CHROMA_POS_BITS-1:0] s1_chroma_pos_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (s1_ready) begin
         s1_valid_in = req_valid;
      end
      rsp_valid_in = rsp_valid_ff;
      if (out_ready) begin
         rsp_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_pixel_ff      <= req_data;
         s1_chroma_ff     <= chroma_cur;
         s1_last_ff       <= frame_end;
         s1_src_index_ff  <= src_row_cur + SRC_INDEX_BITS'(column_cur);
         s1_luma_pos_ff   <= luma_pos_cur;
         s1_chroma_pos_ff <= chroma_pos_cur;
      end
   end

   // stage two: weight sums and offsets
   logic [LUMA_SUM_BITS-1:0]   luma_sum;
   logic [CHROMA_SUM_BITS-1:0] cb_sum, cr_sum;
   logic [SUM_BITS-1:0]        cb_sum_addr, cr_sum_addr;
   logic [SRC_PROD_BITS-1:0]   src_prod;
   rsp_payload_type            rsp_data_ff, rsp_data_in;

   always_comb begin
      luma_sum = LUMA_SUM_BITS'(s1_pixel_ff.red)   * LUMA_SUM_BITS'(Y_R_WEIGHT)
               + LUMA_SUM_BITS'(s1_pixel_ff.green) * LUMA_SUM_BITS'(Y_G_WEIGHT)
               + LUMA_SUM_BITS'(s1_pixel_ff.blue)  * LUMA_SUM_BITS'(Y_B_WEIGHT);
      cb_sum = CHROMA_SUM_BITS'(CHROMA_BIAS)
             + CHROMA_SUM_BITS'(s1_pixel_ff.blue)  * CHROMA_SUM_BITS'(CB_B_WEIGHT)
             - CHROMA_SUM_BITS'(s1_pixel_ff.red)   * CHROMA_SUM_BITS'(CB_R_WEIGHT)
             - CHROMA_SUM_BITS'(s1_pixel_ff.green) * CHROMA_SUM_BITS'(CB_G_WEIGHT);
      cr_sum = CHROMA_SUM_BITS'(CHROMA_BIAS)
             + CHROMA_SUM_BITS'(s1_pixel_ff.red)   * CHROMA_SUM_BITS'(CR_R_WEIGHT)
             - CHROMA_SUM_BITS'(s1_pixel_ff.green) * CHROMA_SUM_BITS'(CR_G_WEIGHT)
             - CHROMA_SUM_BITS'(s1_pixel_ff.blue)  * CHROMA_SUM_BITS'(CR_B_WEIGHT);
      cb_sum_addr = SUM_BITS'(plane_ff) + SUM_BITS'(s1_chroma_pos_ff);
      cr_sum_addr = cb_sum_addr + SUM_BITS'(plane_ff >> 2);
      src_prod    = SRC_PROD_BITS'(s1_src_index_ff) * SRC_PROD_BITS'(bpp_ff);

      rsp_data_in.luma = luma_sum[WEIGHT_SHIFT +: COMPONENT_BITS]
                       + COMPONENT_BITS'(LUMA_OFFSET);
      rsp_data_in.luma_address   = s1_luma_pos_ff;
      rsp_data_in.chroma_valid   = s1_chroma_ff;
      rsp_data_in.blue_diff      = COMPONENT_BITS'(CHROMA_OFFSET);
      rsp_data_in.red_diff       = COMPONENT_BITS'(CHROMA_OFFSET);
      rsp_data_in.cb_address     = '0;
      rsp_data_in.cr_address     = '0;
      if (s1_chroma_ff) begin
         rsp_data_in.blue_diff  = cb_sum[WEIGHT_SHIFT +: COMPONENT_BITS];
         rsp_data_in.red_diff   = cr_sum[WEIGHT_SHIFT +: COMPONENT_BITS];
         rsp_data_in.cb_address = CHROMA_ADDR_BITS'(cb_sum_addr);
         rsp_data_in.cr_address = CHROMA_ADDR_BITS'(cr_sum_addr);
      end
      rsp_data_in.source_address = SRC_ADDR_BITS'(src_prod);
      rsp_data_in.last_of_frame  = s1_last_ff;
   end

   always_ff @(posedge clock) begin
      if (out_ready && s1_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> tb/tb_rgb_to_i420_converter.sv
`timescale 1ns / 1ps

module tb_rgb_to_i420_converter;
   import rgbi420_pkg::*;

   localparam int FRAME_MAX_W    = 4096;
   localparam int FRAME_MAX_H    = 4096;
   localparam int RANDOM_PIXELS  = 1950;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic            known;
      req_payload_type pixel;
      rsp_payload_type yuv;
   } pixel_case_type;

   // reset geometry: 2x1 frame, 4 bytes per pixel, so every pair is one frame
   localparam pixel_case_type PIXEL_CASES [14] = '{
      {1'b1, 24'h000000, 8'd16,  24'd0, 1'b1, 8'd128, 8'd128, 25'd2, 25'd2, 26'd0, 1'b0},
      {1'b1, 24'hFFFFFF, 8'd235, 24'd1, 1'b0, 8'd128, 8'd128, 25'd0, 25'd0, 26'd4, 1'b1},
      {1'b1, 24'hFF0000, 8'd81,  24'd0, 1'b1, 8'd90,  8'd239, 25'd2, 25'd2, 26'd0, 1'b0},
      {1'b1, 24'h0000FF, 8'd40,  24'd1, 1'b0, 8'd128, 8'd128, 25'd0, 25'd0, 26'd4, 1'b1},
      {1'b1, 24'h0000FF, 8'd40,  24'd0, 1'b1, 8'd239, 8'd110, 25'd2, 25'd2, 26'd0, 1'b0},
      {1'b1, 24'hFF0000, 8'd81,  24'd1, 1'b0, 8'd128, 8'd128, 25'd0, 25'd0, 26'd4, 1'b1},
      {1'b1, 24'hFFFF00, 8'd210, 24'd0, 1'b1, 8'd16,  8'd145, 25'd2, 25'd2, 26'd0, 1'b0},
      {1'b1, 24'h00FFFF, 8'd169, 24'd1, 1'b0, 8'd128, 8'd128, 25'd0, 25'd0, 26'd4, 1'b1},
      {1'b1, 24'h00FFFF, 8'd169, 24'd0, 1'b1, 8'd165, 8'd16,  25'd2, 25'd2, 26'd0, 1'b0},
      {1'b1, 24'h00FF00, 8'd144, 24'd1, 1'b0, 8'd128, 8'd128, 25'd0, 25'd0, 26'd4, 1'b1},
      {1'b0, 24'h55AA55, 126'd0},
      {1'b0, 24'hAA55AA, 126'd0},
      {1'b0, 24'h807F01, 126'd0},
      {1'b0, 24'h01FE80, 126'd0}
   };

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   req_payload_type req_data;
   logic            rsp_valid;
   logic            rsp_stall;
   rsp_payload_type rsp_data;
   logic            csr_write;
   csr_index_type   csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   rgb_to_i420_converter u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // register mirror and frame walk of the converter
   logic [12:0] width_reg  = 13'd2;
   logic [12:0] height_reg = 13'd1;
   logic        flip_reg   = 1'b0;
   logic [2:0]  bpp_reg    = 3'd4;
   int unsigned col_pos, row_pos, luma_index, chroma_index, src_row_base;

   rsp_payload_type yuv_expected [$];
   int unsigned     mismatches;
   int unsigned     pixels_sent;
   bit              steady_flow;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void rewind_frame();
      col_pos      = 0;
      row_pos      = 0;
      luma_index   = 0;
      chroma_index = 0;
      src_row_base = 0;
   endfunction

   function automatic rsp_payload_type convert_pixel(req_payload_type px);
      int unsigned     w, h, plane, k;
      int              r, g, b, su, sv;
      logic            chroma_here;
      rsp_payload_type yuv;
      w = width_reg & 13'h1FFE;
      if (w < 2) w = 2;
      if (w > FRAME_MAX_W) w = FRAME_MAX_W;
      h = height_reg;
      if (h < 1) h = 1;
      if (h > FRAME_MAX_H) h = FRAME_MAX_H;
      r = px.red;
      g = px.green;
      b = px.blue;
      plane = w * h;
      if (col_pos >= w || row_pos >= h) rewind_frame();
      if (col_pos == 0 && row_pos == 0)
         src_row_base = flip_reg ? (((h - 1) * w) & 32'hFFFFFF) : 0;
      chroma_here = !row_pos[0] && !col_pos[0];
      k = (src_row_base + col_pos) & 32'hFFFFFF;

      yuv.luma         = 8'(((66 * r + 129 * g + 25 * b) >> 8) + 16);
      yuv.luma_address = 24'(luma_index);
      yuv.chroma_valid = chroma_here;
      if (chroma_here) begin
         su = -38 * r - 74 * g + 112 * b + 32768;
         sv = 112 * r - 94 * g - 18 * b + 32768;
         yuv.blue_diff  = 8'(su >> 8);
         yuv.red_diff   = 8'(sv >> 8);
         yuv.cb_address = 25'(plane + chroma_index);
         yuv.cr_address = 25'(plane + plane / 4 + chroma_index);
      end else begin
         yuv.blue_diff  = 8'd128;
         yuv.red_diff   = 8'd128;
         yuv.cb_address = '0;
         yuv.cr_address = '0;
      end
      yuv.source_address = 26'(k * bpp_reg);
      yuv.last_of_frame  = (row_pos == h - 1) && (col_pos == w - 1);

      luma_index = (luma_index + 1) & 32'hFFFFFF;
      if (chroma_here) chroma_index = (chroma_index + 1) & 32'h3FFFFF;
      col_pos++;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
         src_row_base = (flip_reg ? src_row_base - w : src_row_base + w) & 32'hFFFFFF;
         if (row_pos >= h) rewind_frame();
      end
      return yuv;
   endfunction

   function automatic logic [7:0] random_level();
      case ($urandom_range(7, 0))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(255, 0));
      endcase
   endfunction

   task automatic send_pixel(req_payload_type px, logic known, rsp_payload_type yuv);
      int unsigned     gap;
      rsp_payload_type predicted;
      gap = steady_flow ? 0 : $urandom_range(16, 0);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= px;
      do @(posedge clock); while (req_stall);
      predicted = convert_pixel(px);
      yuv_expected.push_back(known ? yuv : predicted);
      pixels_sent++;
   endtask

   task automatic drain_pixels();
      req_valid <= 1'b0;
      do @(posedge clock); while (yuv_expected.size() != 0);
   endtask

   task automatic write_register(csr_index_type idx, logic [CSR_DATA_BITS-1:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_FRAME_WIDTH:     width_reg  = value;
         CSR_FRAME_HEIGHT:    height_reg = value;
         CSR_FLIP_VERTICAL:   flip_reg   = value[0];
         CSR_BYTES_PER_PIXEL: bpp_reg    = value[2:0];
         default: ;
      endcase
   endtask

   task automatic program_frame(logic [12:0] w, h, flip, bpp);
      write_register(CSR_FRAME_WIDTH, w);
      write_register(CSR_FRAME_HEIGHT, h);
      write_register(CSR_FLIP_VERTICAL, flip);
      write_register(CSR_BYTES_PER_PIXEL, bpp);
      csr_write <= 1'b0;
   endtask

   task automatic run_pixels(int unsigned count);
      req_payload_type px;
      for (int unsigned i = 0; i < count; i++) begin
         px = {random_level(), random_level(), random_level()};
         send_pixel(px, 1'b0, '0);
      end
      drain_pixels();
   endtask

   task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
      mismatches++;
      $display("%0t: %s mismatch, got %0d expected %0d", $realtime, what, got, want);
   endtask

   always @(posedge clock) begin : yuv_check
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (yuv_expected.size() == 0) begin
            report_mismatch("unexpected beat, luma", rsp_data.luma, 0);
         end else begin
            want = yuv_expected.pop_front();
            if (rsp_data.luma !== want.luma)
               report_mismatch("luma", rsp_data.luma, want.luma);
            if (rsp_data.luma_address !== want.luma_address)
               report_mismatch("luma_address", rsp_data.luma_address, want.luma_address);
            if (rsp_data.chroma_valid !== want.chroma_valid)
               report_mismatch("chroma_valid", rsp_data.chroma_valid, want.chroma_valid);
            if (rsp_data.blue_diff !== want.blue_diff)
               report_mismatch("blue_diff", rsp_data.blue_diff, want.blue_diff);
            if (rsp_data.red_diff !== want.red_diff)
               report_mismatch("red_diff", rsp_data.red_diff, want.red_diff);
            if (rsp_data.cb_address !== want.cb_address)
               report_mismatch("cb_address", rsp_data.cb_address, want.cb_address);
            if (rsp_data.cr_address !== want.cr_address)
               report_mismatch("cr_address", rsp_data.cr_address, want.cr_address);
            if (rsp_data.source_address !== want.source_address)
               report_mismatch("source_address", rsp_data.source_address,
                               want.source_address);
            if (rsp_data.last_of_frame !== want.last_of_frame)
               report_mismatch("last_of_frame", rsp_data.last_of_frame, want.last_of_frame);
         end
      end
   end

   // sink side: a fresh stall draw for every result beat
   initial begin : yuv_sink
      int unsigned hold;
      rsp_stall <= 1'b0;
      @(posedge clock);
      forever begin
         hold = steady_flow ? 0 : $urandom_range(16, 0);
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin : watchdog
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write)
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("rgb_to_i420_converter verification failed");
      $finish;
   end

   initial begin : stimulus
      int unsigned start_count;
      bit          write_all;
      logic [12:0] value;
      rewind_frame();
      mismatches  = 0;
      pixels_sent = 0;
      steady_flow = 1'b0;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_write <= 1'b0;
      csr_index <= CSR_FRAME_WIDTH;
      csr_wdata <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (PIXEL_CASES[i])
         send_pixel(PIXEL_CASES[i].pixel, PIXEL_CASES[i].known, PIXEL_CASES[i].yuv);
      drain_pixels();

      // clamped extremes: max flipped, minimum, wide row, max flipped at zero bpp
      start_count = pixels_sent;
      program_frame(13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF);
      run_pixels(40);
      program_frame(13'd0, 13'd0, 13'd0, 13'd0);
      run_pixels(20);
      steady_flow = 1'b1;
      program_frame(13'd4096, 13'd2, 13'h1FFE, 13'd3);
      run_pixels(60);
      program_frame(13'd4097, 13'd4096, 13'd1, 13'h1FF8);
      run_pixels(30);

      write_all = 1'b1;
      while (pixels_sent - start_count < RANDOM_PIXELS) begin
         steady_flow = ($urandom_range(3, 0) == 0);
         for (int i = 0; i < 4; i++) begin
            if (write_all || $urandom_range(1, 0) == 1) begin
               case (csr_index_type'(i))
                  CSR_FRAME_WIDTH:
                     value = ($urandom_range(7, 0) == 0) ? 13'($urandom_range(8191, 0))
                                                        : 13'($urandom_range(12, 0));
                  CSR_FRAME_HEIGHT:
                     value = ($urandom_range(7, 0) == 0) ? 13'($urandom_range(8191, 0))
                                                        : 13'($urandom_range(8, 0));
                  default:
                     value = 13'($urandom_range(8191, 0));
               endcase
               write_register(csr_index_type'(i), value);
            end
         end
         csr_write <= 1'b0;
         write_all = 1'b0;
         run_pixels($urandom_range(100, 4));
      end

      repeat (8) @(posedge clock);
      if (mismatches == 0 && yuv_expected.size() == 0)
         $display("rgb_to_i420_converter verification clean");
      else
         $display("rgb_to_i420_converter verification failed");
      $finish;
   end

endmodule
